@@ rtl/greedy_unique_pair_filter_defines.svh @@
// ----------------------------------------------------------------------------
// greedy unique pair filter assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef GREEDY_UNIQUE_PAIR_FILTER_DEFINES_SVH
`define GREEDY_UNIQUE_PAIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define GUPF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gupf check failed");

// condition must never be seen outside reset
`define GUPF_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("gupf forbidden condition");

`else

`define GUPF_ASSERT(label, clk, rst, prop)
`define GUPF_NEVER(label, clk, rst, cond)

`endif

`endif

@@ rtl/gupf_pkg.sv @@
// ----------------------------------------------------------------------------
// gupf_pkg
// shared types and constants of the greedy unique pair filter
// ----------------------------------------------------------------------------
package gupf_pkg;

   // token field width and the span of token values it can carry
   localparam int TOKEN_W     = 12;
   localparam int TOKEN_SPAN  = 2 ** TOKEN_W;
   localparam int TOKEN_COUNT = 4096;

   // epoch tags: entries whose tag matches the live epoch are used
   localparam int EPOCH_W = 4;

   typedef logic [EPOCH_W-1:0] epoch_type;

   // all ones marks an entry as empty, the live epoch never takes it
   localparam epoch_type EPOCH_FILL = epoch_type'((2 ** EPOCH_W) - 1);
   localparam epoch_type EPOCH_LAST = epoch_type'((2 ** EPOCH_W) - 2);

   typedef enum logic [1:0] {
      OP_OFFER       = 2'd0,
      OP_MARK_FIRST  = 2'd1,
      OP_MARK_SECOND = 2'd2,
      OP_CLEAR       = 2'd3
   } opcode_type;

   // epoch controller status seen by the datapath
   typedef struct packed {
      logic      sweep;
      epoch_type epoch;
   } epoch_status_type;

endpackage

@@ rtl/gupf_tag_ram.sv @@
// ----------------------------------------------------------------------------
// gupf_tag_ram
// one used-token map held as epoch tags, one write and one read port
// ----------------------------------------------------------------------------
module gupf_tag_ram #(
   parameter int MAP_DEPTH = gupf_pkg::TOKEN_COUNT,
   parameter int ADDR_W    = $clog2(MAP_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  gupf_pkg::epoch_type wr_tag,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output gupf_pkg::epoch_type rd_tag
);

   gupf_pkg::epoch_type mem [MAP_DEPTH];
   gupf_pkg::epoch_type rd_tag_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_tag;
      end
   end

   // registered read, held while no word is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= mem[rd_addr];
      end
   end

   assign rd_tag = rd_tag_ff;

endmodule

@@ rtl/gupf_epoch_ctrl.sv @@
// ----------------------------------------------------------------------------
// gupf_epoch_ctrl
// live epoch counter and the sweep that refills both maps on wrap and reset
// ----------------------------------------------------------------------------
module gupf_epoch_ctrl #(
   parameter int MAP_DEPTH = gupf_pkg::TOKEN_COUNT,
   parameter int ADDR_W    = $clog2(MAP_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear_go,
   output gupf_pkg::epoch_status_type status,
   output logic [ADDR_W-1:0]          sweep_addr
);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_SWEEP = 2'b10
   } sweep_state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);

   sweep_state_type     state_ff, state_in;
   gupf_pkg::epoch_type epoch_ff, epoch_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;

   // next state: a clear bumps the epoch, the last epoch starts a sweep
   always_comb begin
      state_in = state_ff;
      epoch_in = epoch_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_RUN: begin
            if (clear_go) begin
               if (epoch_ff == gupf_pkg::EPOCH_LAST) begin
                  epoch_in = '0;
                  addr_in  = '0;
                  state_in = ST_SWEEP;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_SWEEP;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         epoch_ff <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         epoch_ff <= epoch_in;
         addr_ff  <= addr_in;
      end
   end

   assign status.sweep = (state_ff == ST_SWEEP);
   assign status.epoch = epoch_ff;
   assign sweep_addr   = addr_ff;

endmodule

@@ rtl/greedy_unique_pair_filter.sv @@
// ----------------------------------------------------------------------------
// greedy_unique_pair_filter
// greedy one-to-one matcher of token pairs with two used-token maps
// ----------------------------------------------------------------------------
//  channel  ports                                                     role
//  req      req_valid req_stall req_opcode req_first/second_token     word in
//  rsp      rsp_valid rsp_stall rsp_chosen_first/second               pair out
//
//  one word per cycle while req is not stalled; an accepted offer has its
//  map tags read at the edge that takes it, then is decided and written into
//  the result register unless a waiting result holds it.
//  after reset req is stalled while both maps are swept to the empty tag;
//  every fifteenth clear stalls it likewise while both maps are swept.
//  a waiting result stalls only an offer that also wins; other words pass.
// ----------------------------------------------------------------------------
`include "greedy_unique_pair_filter_defines.svh"

module greedy_unique_pair_filter #(
   parameter int TOKEN_COUNT = gupf_pkg::TOKEN_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [gupf_pkg::TOKEN_W-1:0] req_first_token,
   input  logic [gupf_pkg::TOKEN_W-1:0] req_second_token,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gupf_pkg::TOKEN_W-1:0] rsp_chosen_first,
   output logic [gupf_pkg::TOKEN_W-1:0] rsp_chosen_second
);

   localparam int MAP_DEPTH = (TOKEN_COUNT < gupf_pkg::TOKEN_SPAN) ?
                              TOKEN_COUNT : gupf_pkg::TOKEN_SPAN;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);

   gupf_pkg::epoch_status_type status;
   logic [ADDR_W-1:0]          sweep_addr;

   // stage one: the word whose map tags are being read
   logic                         s1_valid_ff, s1_valid_in;
   gupf_pkg::opcode_type         s1_opcode_ff;
   logic [gupf_pkg::TOKEN_W-1:0] s1_first_ff, s1_second_ff;
   logic                         fwd_first_ff, fwd_first_in;
   logic                         fwd_second_ff, fwd_second_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gupf_pkg::TOKEN_W-1:0] rsp_first_ff, rsp_second_ff;

   gupf_pkg::epoch_type rd_first_tag, rd_second_tag;

   logic accept;
   logic first_ok, second_ok;
   logic first_hit, second_hit;
   logic offer_win, s1_advance, clear_go, clear_wrap;
   logic write_first, write_second;
   logic ram_first_we, ram_second_we;
   logic [ADDR_W-1:0] ram_first_wa, ram_second_wa;
   gupf_pkg::epoch_type ram_wtag;

   // decide on the word in stage one
   always_comb begin
      first_ok   = 32'(s1_first_ff) < 32'(TOKEN_COUNT);
      second_ok  = 32'(s1_second_ff) < 32'(TOKEN_COUNT);
      first_hit  = fwd_first_ff || (rd_first_tag == status.epoch);
      second_hit = fwd_second_ff || (rd_second_tag == status.epoch);
      offer_win  = s1_valid_ff && (s1_opcode_ff == gupf_pkg::OP_OFFER) &&
                   first_ok && second_ok && !first_hit && !second_hit;
      s1_advance = !(offer_win && rsp_valid_ff && rsp_stall);
      clear_go   = s1_valid_ff && (s1_opcode_ff == gupf_pkg::OP_CLEAR);
      clear_wrap = clear_go && (status.epoch == gupf_pkg::EPOCH_LAST);
      write_first  = s1_valid_ff && s1_advance &&
                     (offer_win ||
                      ((s1_opcode_ff == gupf_pkg::OP_MARK_FIRST) && first_ok));
      write_second = s1_valid_ff && s1_advance &&
                     (offer_win ||
                      ((s1_opcode_ff == gupf_pkg::OP_MARK_SECOND) && second_ok));
   end

   // input handshake
   assign req_stall = status.sweep || (s1_valid_ff && (clear_wrap || !s1_advance));
   assign accept    = req_valid && !req_stall;

   // forward a mark written at the same edge the new word reads its map
   always_comb begin
      fwd_first_in  = write_first &&
                      (s1_first_ff[ADDR_W-1:0] == req_first_token[ADDR_W-1:0]);
      fwd_second_in = write_second &&
                      (s1_second_ff[ADDR_W-1:0] == req_second_token[ADDR_W-1:0]);
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff  <= gupf_pkg::opcode_type'(req_opcode);
         s1_first_ff   <= req_first_token;
         s1_second_ff  <= req_second_token;
         fwd_first_ff  <= fwd_first_in;
         fwd_second_ff <= fwd_second_in;
      end
   end

   // result register
   always_comb begin
      if (offer_win && s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (offer_win && s1_advance) begin
         rsp_first_ff  <= s1_first_ff;
         rsp_second_ff <= s1_second_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_first  = rsp_first_ff;
   assign rsp_chosen_second = rsp_second_ff;

   // map write ports: sweep fills the empty tag, otherwise mark with live epoch
   always_comb begin
      if (status.sweep) begin
         ram_first_we  = 1'b1;
         ram_second_we = 1'b1;
         ram_first_wa  = sweep_addr;
         ram_second_wa = sweep_addr;
         ram_wtag      = gupf_pkg::EPOCH_FILL;
      end else begin
         ram_first_we  = write_first;
         ram_second_we = write_second;
         ram_first_wa  = s1_first_ff[ADDR_W-1:0];
         ram_second_wa = s1_second_ff[ADDR_W-1:0];
         ram_wtag      = status.epoch;
      end
   end

   gupf_epoch_ctrl #(
      .MAP_DEPTH (MAP_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_epoch (
      .clock      (clock),
      .reset      (reset),
      .clear_go   (clear_go),
      .status     (status),
      .sweep_addr (sweep_addr)
   );

   gupf_tag_ram #(
      .MAP_DEPTH (MAP_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_first_map (
      .clock   (clock),
      .wr_en   (ram_first_we),
      .wr_addr (ram_first_wa),
      .wr_tag  (ram_wtag),
      .rd_en   (accept),
      .rd_addr (req_first_token[ADDR_W-1:0]),
      .rd_tag  (rd_first_tag)
   );

   gupf_tag_ram #(
      .MAP_DEPTH (MAP_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_second_map (
      .clock   (clock),
      .wr_en   (ram_second_we),
      .wr_addr (ram_second_wa),
      .wr_tag  (ram_wtag),
      .rd_en   (accept),
      .rd_addr (req_second_token[ADDR_W-1:0]),
      .rd_tag  (rd_second_tag)
   );

   // checks
   `GUPF_NEVER(a_no_accept_in_sweep, clock, reset, status.sweep && accept)
   `GUPF_ASSERT(a_wrap_starts_sweep, clock, reset, (clear_wrap && !status.sweep) |=> status.sweep)
   `GUPF_NEVER(a_epoch_not_fill, clock, reset, status.epoch == gupf_pkg::EPOCH_FILL)
   `GUPF_ASSERT(a_win_loads_rsp, clock, reset, (offer_win && s1_advance) |=> rsp_valid_ff)

endmodule
